// ----- hw/rtl/grid_triangle_interpolator_2d_macros.svh -----
// assertion macros used by the checker file
`ifndef GRID_TRIANGLE_INTERPOLATOR_2D_MACROS_SVH
`define GRID_TRIANGLE_INTERPOLATOR_2D_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define GTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gti_pkg.sv -----
// shared types and constants of the triangulated grid interpolator
package gti_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int WEIGHT_BITS = 30;
    localparam int FRAC_W      = WEIGHT_BITS + 1;
    localparam int INDEX_W     = 12;
    localparam int ACTION_W    = 2;
    localparam int S_TDATA_W   = 112;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << WEIGHT_BITS;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic [ACTION_W-1:0] ACT_LOAD_X = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_Y = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_Z = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_X_POINTS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_POINTS = 8'd1;

    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_MIN = 7'd2;

    typedef enum logic [2:0] {
        K_LOAD_X,
        K_LOAD_Y,
        K_LOAD_Z,
        K_QUERY,
        K_DROP
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic [INDEX_W-1:0]             index;
        logic signed [VALUE_BITS-1:0]   value;
        logic signed [VALUE_BITS-1:0]   qx;
        logic signed [VALUE_BITS-1:0]   qy;
        logic                           last;
    } t_cmd;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

endpackage

// ----- hw/rtl/grid_triangle_interpolator_2d.sv -----
// Piecewise linear 2-D interpolation over a triangulated grid. Load the X and Y
// grid coordinates (sorted, ascending) and the Z table item by item, set the
// point counts through the configuration port while idle, then send query items.
// Each query returns one result; loads return none. A point outside the grid
// gives the largest value with the outside flag set. Loads retire at one per
// cycle in the back end while no query is running. The per-axis bracketing
// search waits on the single registered read port of each grid store, and
// a fraction strictly inside its cell goes through a 30-step bit-serial
// divider. A four-entry queue lets new items be taken while a query runs or
// a result waits to be taken.
module grid_triangle_interpolator_2d #(
    parameter int MAX_X_POINTS = 64,
    parameter int MAX_Y_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // load_index[11:0], load_value[43:12], query_x[75:44], query_y[107:76], zero
    input  logic [gti_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // action
    input  logic [gti_pkg::ACTION_W-1:0]        i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // interp_value
    output logic [gti_pkg::VALUE_BITS-1:0]      o_m_tdata,
    // outside_grid
    output logic                                o_m_tuser,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gti_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [gti_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    gti_pkg::t_cmd    w_push_cmd;
    gti_pkg::t_cmd    w_pop_cmd;
    gti_pkg::t_cfg_wr w_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    gti_front #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    gti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    gti_back #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_empty    (w_empty),
        .i_cmd      (w_pop_cmd),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- hw/rtl/gti_front.sv -----
// front end: takes stream items, classifies them and drops out-of-range loads
module gti_front #(
    parameter int MAX_X_POINTS = 64,
    parameter int MAX_Y_POINTS = 64
) (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [gti_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [gti_pkg::ACTION_W-1:0]    i_s_tuser,
    input  logic                            i_s_tlast,
    input  logic                            i_full,
    output logic                            o_push,
    output gti_pkg::t_cmd                   o_cmd
);

    localparam int Z_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;

    logic [gti_pkg::INDEX_W-1:0] w_index;

    assign w_index = i_s_tdata[11:0];

    always_comb begin
        o_cmd.index = w_index;
        o_cmd.value = i_s_tdata[43:12];
        o_cmd.qx    = i_s_tdata[75:44];
        o_cmd.qy    = i_s_tdata[107:76];
        o_cmd.last  = i_s_tlast;
        case (i_s_tuser)
            gti_pkg::ACT_LOAD_X: begin
                o_cmd.kind = (32'(w_index) < 32'(MAX_X_POINTS)) ? gti_pkg::K_LOAD_X
                                                                 : gti_pkg::K_DROP;
            end
            gti_pkg::ACT_LOAD_Y: begin
                o_cmd.kind = (32'(w_index) < 32'(MAX_Y_POINTS)) ? gti_pkg::K_LOAD_Y
                                                                 : gti_pkg::K_DROP;
            end
            gti_pkg::ACT_LOAD_Z: begin
                o_cmd.kind = (32'(w_index) < 32'(Z_DEPTH)) ? gti_pkg::K_LOAD_Z
                                                            : gti_pkg::K_DROP;
            end
            default: begin
                o_cmd.kind = gti_pkg::K_QUERY;
            end
        endcase
    end

    assign o_s_tready = !i_full;
    // a load beyond its store is taken and forgotten
    assign o_push     = i_s_tvalid && !i_full && (o_cmd.kind != gti_pkg::K_DROP);

endmodule

// ----- hw/rtl/gti_queue.sv -----
// short command queue between front end and back end
module gti_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gti_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output gti_pkg::t_cmd   o_cmd,
    output logic            o_empty
);

    localparam int QAW = $clog2(gti_pkg::QUEUE_DEPTH);

    gti_pkg::t_cmd  r_mem [gti_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(gti_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/gti_div.sv -----
// bit-serial restoring divider for the cell fractions, one quotient bit per cycle
module gti_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [32:0]                     i_off,
    input  logic [32:0]                     i_span,
    output logic                            o_done,
    output logic [gti_pkg::WEIGHT_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(gti_pkg::WEIGHT_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gti_pkg::WEIGHT_BITS - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [33:0]                     r_rem;
    logic [32:0]                     r_den;
    logic [gti_pkg::WEIGHT_BITS-1:0] r_quot;
    logic [33:0]                     w_trial;
    logic                            w_fit;

    // remainder stays below the divisor, so its top bit is always clear
    assign w_trial = {r_rem[32:0], 1'b0};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_off};
                r_den  <= i_span;
            end else if (r_busy) begin
                r_rem  <= w_fit ? (w_trial - {1'b0, r_den}) : w_trial;
                r_quot <= {r_quot[gti_pkg::WEIGHT_BITS-2:0], w_fit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hw/rtl/gti_back.sv -----
// back end: grid and z stores, bracketing search, fractions and weighted sum
module gti_back #(
    parameter int MAX_X_POINTS = 64,
    parameter int MAX_Y_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gti_pkg::t_cfg_wr                    i_cfg,
    input  logic                                i_empty,
    input  gti_pkg::t_cmd                       i_cmd,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gti_pkg::VALUE_BITS-1:0]      o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int XAW     = $clog2(MAX_X_POINTS);
    localparam int YAW     = $clog2(MAX_Y_POINTS);
    localparam int XCW     = $clog2(MAX_X_POINTS + 1);
    localparam int YCW     = $clog2(MAX_Y_POINTS + 1);
    localparam int AW      = (XAW > YAW) ? XAW : YAW;
    localparam int Z_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int ZAW     = $clog2(Z_DEPTH);
    localparam int PW      = YAW + XCW;
    localparam int BW      = PW + 1;
    localparam int VB      = gti_pkg::VALUE_BITS;
    localparam int FW      = gti_pkg::FRAC_W;

    typedef enum logic [4:0] {
        S_IDLE, S_A0, S_A1, S_A2, S_A3, S_SEARCH, S_SW1, S_SW2,
        S_F0, S_F1, S_F2, S_DIV,
        S_Z0, S_Z1, S_Z2, S_Z3, S_Z4, S_Z5, S_Z6, S_Z7, S_DONE
    } t_state;

    t_state                 r_state;
    logic [XCW-1:0]         r_nx;
    logic [YCW-1:0]         r_ny;
    logic signed [VB-1:0]   r_xmem [MAX_X_POINTS];
    logic signed [VB-1:0]   r_ymem [MAX_Y_POINTS];
    logic signed [VB-1:0]   r_zmem [Z_DEPTH];
    logic signed [VB-1:0]   r_xrd;
    logic signed [VB-1:0]   r_yrd;
    logic signed [VB-1:0]   r_zrd;
    logic [AW-1:0]          r_addr;
    logic [ZAW-1:0]         r_zaddr;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_mid;
    logic                   r_axis;
    logic signed [VB-1:0]   r_qx;
    logic signed [VB-1:0]   r_qy;
    logic                   r_last;
    logic [XAW-1:0]         r_i;
    logic [YAW-1:0]         r_j;
    logic [FW-1:0]          r_a;
    logic [FW-1:0]          r_b;
    logic signed [VB-1:0]   r_g0;
    logic [FW-1:0]          r_w10;
    logic [FW-1:0]          r_w01;
    logic [FW-1:0]          r_wc;
    logic                   r_upper;
    logic [ZAW-1:0]         r_base;
    logic signed [63:0]     r_prod;
    logic signed [63:0]     r_acc;
    logic signed [VB-1:0]   r_res;
    logic                   r_outside;
    logic                   r_ovalid;
    logic [VB-1:0]          r_odata;
    logic                   r_ouser;
    logic                   r_olast;

    logic signed [VB-1:0]   w_g;
    logic signed [VB-1:0]   w_q;
    logic [AW-1:0]          w_top;
    logic [AW-1:0]          w_mid;
    logic                   w_more;
    logic signed [32:0]     w_span;
    logic signed [32:0]     w_off;
    logic                   w_span_pos;
    logic                   w_off_pos;
    logic                   w_need_div;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [gti_pkg::WEIGHT_BITS-1:0] w_quot;
    logic [FW-1:0]          w_frac;
    logic                   w_frac_ready;
    logic [FW:0]            w_sum_ab;
    logic [PW-1:0]          w_jn;
    logic [ZAW-1:0]         w_b00;
    logic signed [33:0]     w_shift;
    logic signed [VB-1:0]   w_sat;
    logic [XCW-1:0]         w_nx_new;
    logic [YCW-1:0]         w_ny_new;
    logic                   w_pop;

    assign w_pop = (r_state == S_IDLE) && !i_empty;
    assign o_pop = w_pop;

    // register writes clamp the point counts into the usable range
    always_comb begin
        if (i_cfg.data < gti_pkg::CFG_COUNT_MIN) begin
            w_nx_new = XCW'(2);
            w_ny_new = YCW'(2);
        end else begin
            w_nx_new = (32'(i_cfg.data) > 32'(MAX_X_POINTS)) ? XCW'(MAX_X_POINTS)
                                                             : XCW'(i_cfg.data);
            w_ny_new = (32'(i_cfg.data) > 32'(MAX_Y_POINTS)) ? YCW'(MAX_Y_POINTS)
                                                             : YCW'(i_cfg.data);
        end
    end

    assign w_g    = r_axis ? r_yrd : r_xrd;
    assign w_q    = r_axis ? r_qy : r_qx;
    assign w_top  = r_axis ? AW'(r_ny - 1'b1) : AW'(r_nx - 1'b1);
    assign w_mid  = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_more = (({1'b0, r_lo} + 1'b1) < {1'b0, r_hi});

    assign w_span     = {w_g[VB-1], w_g} - {r_g0[VB-1], r_g0};
    assign w_off      = {w_q[VB-1], w_q} - {r_g0[VB-1], r_g0};
    assign w_span_pos = !w_span[32] && (w_span != '0);
    assign w_off_pos  = !w_off[32] && (w_off != '0);
    assign w_need_div = w_span_pos && w_off_pos && (w_off < w_span);
    assign w_div_start = (r_state == S_F2) && w_need_div;

    gti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_off   (w_off),
        .i_span  (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_frac       = '0;
        w_frac_ready = 1'b0;
        if (r_state == S_F2) begin
            w_frac_ready = !w_need_div;
            w_frac       = (w_span_pos && w_off_pos) ? gti_pkg::FRAC_ONE : '0;
        end else if (r_state == S_DIV) begin
            w_frac_ready = w_div_done;
            w_frac       = {1'b0, w_quot};
        end
    end

    assign w_sum_ab = {1'b0, r_a} + {1'b0, r_b};
    assign w_jn     = PW'(r_j) * PW'(r_nx);
    assign w_b00    = ZAW'(BW'(r_i) + BW'(w_jn));

    // arithmetic shift by the weight bits floors; with the half added in S_Z6 this gives half-up rounding
    assign w_shift = r_acc[63:gti_pkg::WEIGHT_BITS];
    always_comb begin
        if (w_shift[33:31] == 3'b000 || w_shift[33:31] == 3'b111) begin
            w_sat = w_shift[VB-1:0];
        end else begin
            w_sat = w_shift[33] ? gti_pkg::VALUE_MIN : gti_pkg::VALUE_MAX;
        end
    end

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.kind == gti_pkg::K_LOAD_X) begin
            r_xmem[XAW'(i_cmd.index)] <= i_cmd.value;
        end
        if (w_pop && i_cmd.kind == gti_pkg::K_LOAD_Y) begin
            r_ymem[YAW'(i_cmd.index)] <= i_cmd.value;
        end
        if (w_pop && i_cmd.kind == gti_pkg::K_LOAD_Z) begin
            r_zmem[ZAW'(i_cmd.index)] <= i_cmd.value;
        end
        r_xrd <= r_xmem[XAW'(r_addr)];
        r_yrd <= r_ymem[YAW'(r_addr)];
        r_zrd <= r_zmem[r_zaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nx     <= XCW'(2);
            r_ny     <= YCW'(2);
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    gti_pkg::CFG_X_POINTS: r_nx <= w_nx_new;
                    gti_pkg::CFG_Y_POINTS: r_ny <= w_ny_new;
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop && i_cmd.kind == gti_pkg::K_QUERY) begin
                        r_qx    <= i_cmd.qx;
                        r_qy    <= i_cmd.qy;
                        r_last  <= i_cmd.last;
                        r_axis  <= 1'b0;
                        r_state <= S_A0;
                    end
                end
                S_A0: begin
                    r_addr  <= '0;
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_addr  <= w_top;
                    r_state <= S_A2;
                end
                S_A2: begin
                    if (w_q < w_g) begin
                        r_res     <= gti_pkg::VALUE_MAX;
                        r_outside <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= w_top;
                        r_state <= S_A3;
                    end
                end
                S_A3: begin
                    if (w_q > w_g) begin
                        r_res     <= gti_pkg::VALUE_MAX;
                        r_outside <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_more) begin
                        r_addr  <= w_mid;
                        r_mid   <= w_mid;
                        r_state <= S_SW1;
                    end else begin
                        r_addr  <= r_lo;
                        r_state <= S_F0;
                    end
                end
                S_SW1: begin
                    r_state <= S_SW2;
                end
                S_SW2: begin
                    if (w_q < w_g) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid;
                    end
                    r_state <= S_SEARCH;
                end
                S_F0: begin
                    r_addr  <= r_lo + 1'b1;
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_g0    <= w_g;
                    r_state <= S_F2;
                end
                S_F2, S_DIV: begin
                    if (r_state == S_F2 && w_need_div) begin
                        r_state <= S_DIV;
                    end else if (w_frac_ready) begin
                        if (!r_axis) begin
                            r_a     <= w_frac;
                            r_i     <= XAW'(r_lo);
                            r_axis  <= 1'b1;
                            r_state <= S_A0;
                        end else begin
                            r_b     <= w_frac;
                            r_j     <= YAW'(r_lo);
                            r_state <= S_Z0;
                        end
                    end
                end
                S_Z0: begin
                    r_base <= w_b00;
                    if (w_sum_ab < {1'b0, gti_pkg::FRAC_ONE}) begin
                        r_upper <= 1'b0;
                        r_w10   <= r_a;
                        r_w01   <= r_b;
                        r_wc    <= FW'(gti_pkg::FRAC_ONE - r_a - r_b);
                    end else begin
                        r_upper <= 1'b1;
                        r_w01   <= FW'(gti_pkg::FRAC_ONE - r_a);
                        r_w10   <= FW'(gti_pkg::FRAC_ONE - r_b);
                        r_wc    <= FW'(w_sum_ab - {1'b0, gti_pkg::FRAC_ONE});
                    end
                    r_state <= S_Z1;
                end
                S_Z1: begin
                    r_zaddr <= r_base + ZAW'(1);
                    r_state <= S_Z2;
                end
                S_Z2: begin
                    r_zaddr <= r_base + ZAW'(r_nx);
                    r_state <= S_Z3;
                end
                S_Z3: begin
                    // corner of the chosen triangle opposite the diagonal
                    r_zaddr <= r_upper ? (r_base + ZAW'(r_nx) + ZAW'(1)) : r_base;
                    r_prod  <= $signed({1'b0, r_w10}) * r_zrd;
                    r_state <= S_Z4;
                end
                S_Z4: begin
                    r_prod  <= $signed({1'b0, r_w01}) * r_zrd;
                    r_acc   <= r_prod;
                    r_state <= S_Z5;
                end
                S_Z5: begin
                    r_prod  <= $signed({1'b0, r_wc}) * r_zrd;
                    r_acc   <= r_acc + r_prod;
                    r_state <= S_Z6;
                end
                S_Z6: begin
                    r_acc   <= r_acc + r_prod + (64'sd1 <<< (gti_pkg::WEIGHT_BITS - 1));
                    r_state <= S_Z7;
                end
                S_Z7: begin
                    r_res     <= w_sat;
                    r_outside <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_res;
                        r_ouser  <= r_outside;
                        r_olast  <= r_last;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

endmodule

// ----- hw/rtl/gti_checker.sv -----
// port-level checks for the interpolator, bound to the top level
`include "grid_triangle_interpolator_2d_macros.svh"

module gti_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [gti_pkg::VALUE_BITS-1:0]   o_m_tdata,
    input logic                             o_m_tuser,
    input logic                             o_m_tlast,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready
);

    `GTI_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result item dropped while stalled")
    `GTI_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result item changed")
    `GTI_ASSERT_SAME(a_outside_max, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == gti_pkg::VALUE_MAX, "outside result is not the largest value")
    `GTI_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "register write not taken")

endmodule

bind grid_triangle_interpolator_2d gti_checker u_checker (.*);

// ----- test/tb_grid_triangle_interpolator_2d.sv -----
// testbench for the triangulated grid interpolator: directed corners, unused registers, then random tables and queries
module tb_grid_triangle_interpolator_2d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_DEPTH = 64;
    localparam int Z_SIZE     = 4096;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 200;

    typedef struct {
        logic [31:0] value;
        logic        outside;
        logic        last;
    } t_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [gti_pkg::S_TDATA_W-1:0]   i_s_tdata;
    logic [gti_pkg::ACTION_W-1:0]    i_s_tuser;
    logic                            i_s_tlast;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [gti_pkg::VALUE_BITS-1:0]  o_m_tdata;
    logic                            o_m_tuser;
    logic                            o_m_tlast;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [gti_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [gti_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // predictor copy of the stores and point counts
    int      x_coords [GRID_DEPTH];
    int      y_coords [GRID_DEPTH];
    int      z_values [Z_SIZE];
    int      x_count = 2;
    int      y_count = 2;
    t_result pending_results [$];
    int      fail_count = 0;
    int      rx_hold = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;

    grid_triangle_interpolator_2d u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic bit locate_cell(input int g [GRID_DEPTH], input int n, input longint q,
                                       output int cell_idx);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        cell_idx = 0;
        if (q < longint'(g[0]) || q > longint'(g[n-1])) return 1'b0;
        while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (q < longint'(g[mid])) hi = mid; else lo = mid;
        end
        cell_idx = lo;
        return 1'b1;
    endfunction

    function automatic longint cell_fraction(input longint lo, input longint hi, input longint q);
        longint span;
        longint off;
        span = hi - lo;
        off = q - lo;
        if (span <= 0 || off <= 0) return 0;
        if (off >= span) return longint'(1) << gti_pkg::WEIGHT_BITS;
        return (off << gti_pkg::WEIGHT_BITS) / span;
    endfunction

    function automatic t_result interpolate_point(input int qx, input int qy, input logic last);
        t_result r;
        int      i;
        int      j;
        int      b00;
        longint  one;
        longint  a;
        longint  b;
        longint  w10;
        longint  w01;
        longint  wc;
        longint  zc;
        longint  sum;
        longint  res;
        one = longint'(1) << gti_pkg::WEIGHT_BITS;
        r.last = last;
        if (!locate_cell(x_coords, x_count, qx, i) || !locate_cell(y_coords, y_count, qy, j)) begin
            r.value = gti_pkg::VALUE_MAX;
            r.outside = 1'b1;
            return r;
        end
        a = cell_fraction(x_coords[i], x_coords[i+1], qx);
        b = cell_fraction(y_coords[j], y_coords[j+1], qy);
        b00 = i + j * x_count;
        if (a + b < one) begin
            w10 = a;
            w01 = b;
            wc = one - a - b;
            zc = z_values[b00 % Z_SIZE];
        end else begin
            w01 = one - a;
            w10 = one - b;
            wc = a + b - one;
            zc = z_values[(b00 + x_count + 1) % Z_SIZE];
        end
        sum = w10 * z_values[(b00 + 1) % Z_SIZE] + w01 * z_values[(b00 + x_count) % Z_SIZE]
            + wc * zc;
        res = (sum + (longint'(1) << (gti_pkg::WEIGHT_BITS - 1))) >>> gti_pkg::WEIGHT_BITS;
        if (res > longint'(gti_pkg::VALUE_MAX)) res = gti_pkg::VALUE_MAX;
        if (res < longint'(gti_pkg::VALUE_MIN)) res = gti_pkg::VALUE_MIN;
        r.value = res[31:0];
        r.outside = 1'b0;
        return r;
    endfunction

    // holds valid until the item is taken, then updates the predictor
    task automatic send_item(input logic [gti_pkg::ACTION_W-1:0] action, input int idx,
                             input int value, input int qx, input int qy, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tlast  <= last;
        i_s_tdata  <= {4'b0, qy, qx, value, idx[gti_pkg::INDEX_W-1:0]};
        do @(posedge i_clk); while (!o_s_tready);
        case (action)
            gti_pkg::ACT_LOAD_X: if (idx < GRID_DEPTH) x_coords[idx] = value;
            gti_pkg::ACT_LOAD_Y: if (idx < GRID_DEPTH) y_coords[idx] = value;
            gti_pkg::ACT_LOAD_Z: if (idx < Z_SIZE) z_values[idx] = value;
            default: pending_results.push_back(interpolate_point(qx, qy, last));
        endcase
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [gti_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [6:0] data);
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == gti_pkg::CFG_X_POINTS)
            x_count = data < 2 ? 2 : (data > GRID_DEPTH ? GRID_DEPTH : data);
        else if (idx == gti_pkg::CFG_Y_POINTS)
            y_count = data < 2 ? 2 : (data > GRID_DEPTH ? GRID_DEPTH : data);
    endtask

    task automatic query(input int qx, input int qy, input logic last);
        send_item(gti_pkg::ACT_QUERY, $urandom, $urandom, qx, qy, last);
    endtask

    task automatic load(input logic [gti_pkg::ACTION_W-1:0] action, input int idx,
                        input int value);
        send_item(action, idx, value, $urandom, $urandom, $urandom_range(0, 1));
    endtask

    // style 0: sorted, small steps; 1: spans the full range; 2: repeats and one swapped pair
    task automatic load_axis(input logic [gti_pkg::ACTION_W-1:0] action, input int n,
                             input int style);
        int     g [GRID_DEPTH];
        int     k;
        int     t;
        longint step;
        g[0] = $signed($urandom) >>> 5;
        for (k = 1; k < GRID_DEPTH; k++) begin
            step = (style == 2) ? $urandom_range(0, 2) * $urandom_range(1, 4096)
                                : $urandom_range(1, 1 << 20);
            g[k] = g[k-1] + int'(step);
        end
        if (style == 1)
            for (k = 0; k < n; k++)
                g[k] = int'(longint'(gti_pkg::VALUE_MIN) + (longint'(k) * 64'hFFFF_FFFF) / (n - 1));
        if (style == 2 && n > 3) begin
            k = $urandom_range(1, n - 3);
            t = g[k];
            g[k] = g[k+1];
            g[k+1] = t;
        end
        for (k = 0; k < n; k++) load(action, k, g[k]);
    endtask

    task automatic load_table(input int n_entries, input bit wide);
        for (int k = 0; k < n_entries; k++)
            load(gti_pkg::ACT_LOAD_Z, k, wide ? $urandom : $signed($urandom) >>> 8);
    endtask

    function automatic int pick_coord(input int g [GRID_DEPTH], input int n);
        int          k;
        longint      span;
        longint      lo;
        logic [63:0] r;
        k = $urandom_range(0, n - 2);
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            7: return g[$urandom_range(0, n - 1)];
            8: begin
                if ($urandom_range(0, 1) && g[0] != gti_pkg::VALUE_MIN) return g[0] - 1;
                if (g[n-1] != gti_pkg::VALUE_MAX) return g[n-1] + 1;
                return $urandom;
            end
            9: return $urandom;
            default: begin
                lo = g[k];
                span = longint'(g[k+1]) - lo;
                if (span <= 0) return g[k];
                return int'(lo + longint'(r % (span + 1)));
            end
        endcase
    endfunction

    task automatic test_corner_cases();
        // unit square, corners 0 and 1.0
        for (int k = 0; k < GRID_DEPTH; k++) begin
            load(gti_pkg::ACT_LOAD_X, k, k << 16);
            load(gti_pkg::ACT_LOAD_Y, k, k << 16);
        end
        load(gti_pkg::ACT_LOAD_Z, 0, 32'h0001_0000);
        load(gti_pkg::ACT_LOAD_Z, 1, 32'h0003_0000);
        load(gti_pkg::ACT_LOAD_Z, 2, 32'hFFFB_0000);
        load(gti_pkg::ACT_LOAD_Z, 3, 32'h0007_8000);
        query(0, 0, 1'b0);
        query(32'h1_0000, 0, 1'b0);
        query(0, 32'h1_0000, 1'b1);
        query(32'h1_0000, 32'h1_0000, 1'b0);
        // on the anti-diagonal: upper-right triangle
        query(32'h8000, 32'h8000, 1'b1);
        query(32'h4000, 32'h4000, 1'b0);
        query(32'h1_0000, 32'h0_0001, 1'b0);
        query(-1, 32'h8000, 1'b0);
        query(32'h1_0001, 32'h8000, 1'b1);
        query(32'h8000, -1, 1'b0);
        query(32'h8000, 32'h1_0001, 1'b0);
        query(gti_pkg::VALUE_MIN, gti_pkg::VALUE_MAX, 1'b1);
        query(gti_pkg::VALUE_MAX, gti_pkg::VALUE_MIN, 1'b0);
        // loads beyond the stores are dropped
        load(gti_pkg::ACT_LOAD_X, 4095, 32'h7FFF_FFFF);
        load(gti_pkg::ACT_LOAD_Y, GRID_DEPTH, 32'h8000_0000);
        // extreme Z values, results stay inside the corner range
        load(gti_pkg::ACT_LOAD_Z, 0, gti_pkg::VALUE_MAX);
        load(gti_pkg::ACT_LOAD_Z, 1, gti_pkg::VALUE_MAX);
        load(gti_pkg::ACT_LOAD_Z, 2, gti_pkg::VALUE_MIN);
        load(gti_pkg::ACT_LOAD_Z, 3, gti_pkg::VALUE_MIN);
        query(32'h3333, 32'hCCCC, 1'b1);
        query(32'h5555, 32'h5555, 1'b0);
        // full-range grid and a zero-width cell
        load(gti_pkg::ACT_LOAD_X, 0, gti_pkg::VALUE_MIN);
        load(gti_pkg::ACT_LOAD_X, 1, gti_pkg::VALUE_MAX);
        query(gti_pkg::VALUE_MIN, 32'h8000, 1'b0);
        query(gti_pkg::VALUE_MAX, 32'hFFFF, 1'b1);
        load(gti_pkg::ACT_LOAD_Y, 1, 0);
        query(32'h1234_5678, 0, 1'b0);
    endtask

    task automatic test_random_tables(input int x_raw, input int y_raw, input int n_queries,
                                      input int style, input bit wide_z);
        write_register(gti_pkg::CFG_X_POINTS, 7'(x_raw));
        write_register(gti_pkg::CFG_Y_POINTS, 7'(y_raw));
        load_axis(gti_pkg::ACT_LOAD_X, x_count, style);
        load_axis(gti_pkg::ACT_LOAD_Y, y_count, style);
        load_table(x_count * y_count, wide_z);
        for (int k = 0; k < n_queries; k++) begin
            case ($urandom_range(0, 19))
                0: load(gti_pkg::ACT_LOAD_Z, $urandom_range(0, Z_SIZE - 1), $urandom);
                1: load($urandom_range(0, 1) ? gti_pkg::ACT_LOAD_X : gti_pkg::ACT_LOAD_Y,
                        $urandom_range(GRID_DEPTH, 4095), $urandom);
                default: query(pick_coord(x_coords, x_count), pick_coord(y_coords, y_count),
                               $urandom_range(0, 1));
            endcase
            if (k == n_queries / 2) wait_results_drained();
        end
    endtask

    task automatic test_unused_register();
        write_register(8'd2, 7'h55);
        write_register(8'hFF, 7'h2A);
    endtask

    // result side: random stall after each item taken, none while quiet
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no query pending: interp_value %h", o_m_tdata);
                    fail_count++;
                end else begin
                    t_result r;
                    r = pending_results.pop_front();
                    if (o_m_tdata !== r.value) begin
                        $error("interp_value expected %h actual %h", r.value, o_m_tdata);
                        fail_count++;
                    end
                    if (o_m_tuser !== r.outside) begin
                        $error("outside_grid expected %b actual %b", r.outside, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tlast !== r.last) begin
                        $error("batch_last expected %b actual %b", r.last, o_m_tlast);
                        fail_count++;
                    end
                end
                rx_hold = quiet ? 0 : $urandom_range(0, 13);
                i_m_tready <= (rx_hold == 0);
            end else if (rx_hold > 0) begin
                rx_hold--;
                if (rx_hold == 0) i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= gti_pkg::ACT_LOAD_X;
        i_s_tlast   <= 1'b0;
        i_m_tready  <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= gti_pkg::CFG_X_POINTS;
        i_cfg_data  <= gti_pkg::CFG_COUNT_MIN;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_unused_register();
        test_random_tables(3, 5, 100, 0, 1'b1);
        quiet = 1'b1;
        test_random_tables(1, 7, 80, 2, 1'b0);
        quiet = 1'b0;
        test_random_tables(127, 0, 80, 1, 1'b1);
        test_random_tables(64, 3, 80, 0, 1'b0);
        test_random_tables(10, 4, 100, 2, 1'b1);
        test_random_tables($urandom_range(2, 12), $urandom_range(2, 12), 100, 0, 1'b1);
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
